### src/ubx_mfe_pkg.sv
`default_nettype none
package ubx_mfe_pkg;

	localparam logic [7:0] SYNC_CHAR_1  = 8'hB5;
	localparam logic [7:0] SYNC_CHAR_2  = 8'h62;
	localparam logic [7:0] CLASS_NAV    = 8'h01;
	localparam logic [7:0] CLASS_SEC    = 8'h27;
	localparam logic [7:0] ID_PVT       = 8'h07;
	localparam logic [7:0] ID_POSLLH    = 8'h02;
	localparam logic [7:0] ID_TIMEUTC   = 8'h21;
	localparam logic [7:0] ID_UNIQID    = 8'h03;

	typedef enum logic [1:0] {
		KIND_PVT     = 2'd0,
		KIND_POSLLH  = 2'd1,
		KIND_TIMEUTC = 2'd2,
		KIND_UNIQID  = 2'd3
	} kind_t;

	localparam logic [3:0] FLD_YEAR    = 4'd0;
	localparam logic [3:0] FLD_MONTH   = 4'd1;
	localparam logic [3:0] FLD_DAY     = 4'd2;
	localparam logic [3:0] FLD_HOUR    = 4'd3;
	localparam logic [3:0] FLD_MINUTE  = 4'd4;
	localparam logic [3:0] FLD_SECOND  = 4'd5;
	localparam logic [3:0] FLD_FIX     = 4'd6;
	localparam logic [3:0] FLD_LON     = 4'd7;
	localparam logic [3:0] FLD_LAT     = 4'd8;
	localparam logic [3:0] FLD_HEIGHT  = 4'd9;
	localparam logic [3:0] FLD_MSL     = 4'd10;
	localparam logic [3:0] FLD_HACC    = 4'd11;
	localparam logic [3:0] FLD_VACC    = 4'd12;
	localparam logic [3:0] FLD_SPEED   = 4'd13;
	localparam logic [3:0] FLD_HEADING = 4'd14;
	localparam logic [3:0] FLD_ID      = 4'd15;

	// Where the current byte falls within the message layout.
	typedef struct packed {
		logic       hit;
		logic [2:0] off;
		logic       fin;
		logic [3:0] number;
		logic       last;
	} slot_t;

	typedef struct packed {
		logic  known;
		kind_t kind;
	} class_t;

	function automatic class_t classify(input logic [7:0] cls, input logic [7:0] id);
		class_t c;
		c.known = 1'b1;
		c.kind  = KIND_PVT;
		if (cls == CLASS_NAV && id == ID_PVT) begin
			c.kind = KIND_PVT;
		end else if (cls == CLASS_NAV && id == ID_POSLLH) begin
			c.kind = KIND_POSLLH;
		end else if (cls == CLASS_NAV && id == ID_TIMEUTC) begin
			c.kind = KIND_TIMEUTC;
		end else if (cls == CLASS_SEC && id == ID_UNIQID) begin
			c.kind = KIND_UNIQID;
		end else begin
			c.known = 1'b0;
		end
		return c;
	endfunction

	// Returns all zeros unless pos lies inside the field, so that the
	// disjoint fields of one message can simply be ORed together.
	function automatic slot_t match_slot(input logic [6:0] pos, input logic [6:0] first,
			input logic [2:0] count, input logic [3:0] number, input logic last);
		slot_t      s;
		logic [6:0] offs;
		s    = '0;
		offs = pos - first;
		if (pos >= first && pos < first + {4'b0, count}) begin
			s.hit    = 1'b1;
			s.off    = offs[2:0];
			s.fin    = (offs[2:0] + 3'd1 == count);
			s.number = number;
			s.last   = last & s.fin;
		end
		return s;
	endfunction

	function automatic slot_t lookup(input kind_t kind, input logic [6:0] pos);
		slot_t s;
		case (kind)
			KIND_PVT: begin
				s = match_slot(pos, 7'd10, 3'd2, FLD_YEAR,    1'b0)
				  | match_slot(pos, 7'd12, 3'd1, FLD_MONTH,   1'b0)
				  | match_slot(pos, 7'd13, 3'd1, FLD_DAY,     1'b0)
				  | match_slot(pos, 7'd14, 3'd1, FLD_HOUR,    1'b0)
				  | match_slot(pos, 7'd15, 3'd1, FLD_MINUTE,  1'b0)
				  | match_slot(pos, 7'd16, 3'd1, FLD_SECOND,  1'b0)
				  | match_slot(pos, 7'd26, 3'd1, FLD_FIX,     1'b0)
				  | match_slot(pos, 7'd30, 3'd4, FLD_LON,     1'b0)
				  | match_slot(pos, 7'd34, 3'd4, FLD_LAT,     1'b0)
				  | match_slot(pos, 7'd38, 3'd4, FLD_HEIGHT,  1'b0)
				  | match_slot(pos, 7'd42, 3'd4, FLD_MSL,     1'b0)
				  | match_slot(pos, 7'd46, 3'd4, FLD_HACC,    1'b0)
				  | match_slot(pos, 7'd50, 3'd4, FLD_VACC,    1'b0)
				  | match_slot(pos, 7'd66, 3'd4, FLD_SPEED,   1'b0)
				  | match_slot(pos, 7'd70, 3'd4, FLD_HEADING, 1'b1);
			end
			KIND_POSLLH: begin
				s = match_slot(pos, 7'd10, 3'd4, FLD_LON,    1'b0)
				  | match_slot(pos, 7'd14, 3'd4, FLD_LAT,    1'b0)
				  | match_slot(pos, 7'd18, 3'd4, FLD_HEIGHT, 1'b0)
				  | match_slot(pos, 7'd22, 3'd4, FLD_MSL,    1'b0)
				  | match_slot(pos, 7'd26, 3'd4, FLD_HACC,   1'b0)
				  | match_slot(pos, 7'd30, 3'd4, FLD_VACC,   1'b1);
			end
			KIND_TIMEUTC: begin
				s = match_slot(pos, 7'd18, 3'd2, FLD_YEAR,   1'b0)
				  | match_slot(pos, 7'd20, 3'd1, FLD_MONTH,  1'b0)
				  | match_slot(pos, 7'd21, 3'd1, FLD_DAY,    1'b0)
				  | match_slot(pos, 7'd22, 3'd1, FLD_HOUR,   1'b0)
				  | match_slot(pos, 7'd23, 3'd1, FLD_MINUTE, 1'b0)
				  | match_slot(pos, 7'd24, 3'd1, FLD_SECOND, 1'b1);
			end
			KIND_UNIQID: begin
				s = match_slot(pos, 7'd10, 3'd5, FLD_ID, 1'b1);
			end
			default: begin
				s = '0;
			end
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

### src/ubx_mfe_in_stage.sv
`default_nettype none
module ubx_mfe_in_stage
	import ubx_mfe_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rx_valid,
	output logic            rx_ready,
	input  wire logic [7:0] rx_byte,
	input  wire logic       advance,
	output logic            byte_valid_s1,
	output logic [7:0]      byte_s1
);

	assign rx_ready = !byte_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (rx_valid && rx_ready) begin
			byte_valid_s1 <= 1'b1;
		end else if (advance) begin
			byte_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule
`default_nettype wire

### src/ubx_mfe_parser.sv
`default_nettype none
module ubx_mfe_parser
	import ubx_mfe_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid_s1,
	input  wire logic [7:0] byte_s1,
	output logic            advance,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      message_kind,
	output logic [3:0]      field_number,
	output logic [39:0]     field_value,
	output logic            last_field
);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_SAW_SYNC,
		PH_HEADER,
		PH_BODY
	} phase_t;

	phase_t      phase_q;
	logic [6:0]  pos_q;
	logic [7:0]  class_q;
	kind_t       kind_q;
	logic [39:0] asm_q;

	logic [6:0]  pos_next;
	slot_t       slot;
	class_t      cls;
	logic [39:0] asm_next;

	// A byte moves on whenever the result register is free or being drained.
	assign advance  = byte_valid_s1 && (!out_valid || out_ready);
	assign pos_next = pos_q + 7'd1;
	assign slot     = lookup(kind_q, pos_next);
	assign cls      = classify(class_q, byte_s1);

	always_comb begin
		case (slot.off)
			3'd0:    asm_next = {32'b0, byte_s1};
			3'd1:    asm_next = asm_q | {24'b0, byte_s1, 8'b0};
			3'd2:    asm_next = asm_q | {16'b0, byte_s1, 16'b0};
			3'd3:    asm_next = asm_q | {8'b0, byte_s1, 24'b0};
			3'd4:    asm_next = asm_q | {byte_s1, 32'b0};
			default: asm_next = asm_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			pos_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (advance) begin
				case (phase_q)
					PH_HUNT: begin
						if (byte_s1 == SYNC_CHAR_1) phase_q <= PH_SAW_SYNC;
					end
					PH_SAW_SYNC: begin
						if (byte_s1 == SYNC_CHAR_2) begin
							phase_q <= PH_HEADER;
							pos_q   <= 7'd1;
						end else if (byte_s1 != SYNC_CHAR_1) begin
							phase_q <= PH_HUNT;
							pos_q   <= '0;
						end
					end
					PH_HEADER: begin
						if (pos_next == 7'd2) begin
							pos_q <= pos_next;
						end else if (cls.known) begin
							pos_q   <= pos_next;
							phase_q <= PH_BODY;
						end else begin
							pos_q   <= '0;
							phase_q <= PH_HUNT;
						end
					end
					PH_BODY: begin
						pos_q <= pos_next;
						if (slot.hit && slot.fin) begin
							out_valid <= 1'b1;
						end
						if (slot.hit && slot.last) begin
							pos_q   <= '0;
							phase_q <= PH_HUNT;
						end
					end
					default: begin
						phase_q <= PH_HUNT;
						pos_q   <= '0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && phase_q == PH_HEADER) begin
			if (pos_next == 7'd2) class_q <= byte_s1;
			else kind_q <= cls.kind;
		end
		if (advance && phase_q == PH_BODY && slot.hit) begin
			asm_q <= asm_next;
			if (slot.fin) begin
				message_kind <= kind_q;
				field_number <= slot.number;
				field_value  <= asm_next;
				last_field   <= slot.last;
			end
		end
	end

endmodule
`default_nettype wire

### src/ubx_message_field_extractor_top.sv
// UBX message field extractor.
// The rx channel takes one received UART byte per request (rx_valid, rx_ready,
// rx_byte). The block hunts for the sync pair B5 62, reads class and ID, and
// for NAV-PVT, NAV-POSLLH, NAV-TIMEUTC and SEC-UNIQID messages assembles each
// little-endian field at its fixed offset from the sync byte.
// The out channel (out_valid, out_ready) carries one request per field:
// message_kind, field_number, the raw field_value and last_field. Bytes that
// end no field, and unknown messages, produce nothing.
// A byte goes into an input register, and the parser state and the result
// register are updated from it in one pass once the result register is free
// or draining, so a field's last byte passes the input register and then the
// result register. One byte is taken every cycle as long as the result
// register drains. The rate is set by that single parser step.
// When the receiver stalls, the result holds and an empty input register still
// takes one more byte; then rx_ready falls until out_ready returns.
// Reset clears both valid flags and puts the parser back to hunting for sync.
`default_nettype none
module ubx_message_field_extractor_top
	import ubx_mfe_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rx_valid,
	output logic            rx_ready,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      message_kind,
	output logic [3:0]      field_number,
	output logic [39:0]     field_value,
	output logic            last_field
);

	logic       advance;
	logic       byte_valid_s1;
	logic [7:0] byte_s1;

	ubx_mfe_in_stage u_in_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_valid      (rx_valid),
		.rx_ready      (rx_ready),
		.rx_byte       (rx_byte),
		.advance       (advance),
		.byte_valid_s1 (byte_valid_s1),
		.byte_s1       (byte_s1)
	);

	ubx_mfe_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid_s1 (byte_valid_s1),
		.byte_s1       (byte_s1),
		.advance       (advance),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.message_kind  (message_kind),
		.field_number  (field_number),
		.field_value   (field_value),
		.last_field    (last_field)
	);

`ifndef SYNTHESIS
	a_uniqid_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && message_kind == KIND_UNIQID) |-> (field_number == FLD_ID && last_field))
		else $error("unique id result malformed");

	a_posllh_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && message_kind == KIND_POSLLH)
			|-> (field_number >= FLD_LON && field_number <= FLD_VACC))
		else $error("position message carries a foreign field");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> rx_ready)
		else $error("input stalled while the result register is empty");
`endif

endmodule
`default_nettype wire
